/* design/priority_schedule_wait_times_top_defines.svh */
// Assertion macros for the priority scheduler block.
// Included by the top level; no other dependencies.
`ifndef PRIORITY_SCHEDULE_WAIT_TIMES_TOP_DEFINES_SVH
`define PRIORITY_SCHEDULE_WAIT_TIMES_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PSW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");
// next-cycle implication
`define PSW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");
`else
`define PSW_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PSW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/psw_pkg.sv */
// Package for the priority scheduler: sizes, entry type, microcode ROM.
// No dependencies.
package psw_pkg;

    localparam int MAX_PROCS = 16;
    localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int IDW = 5;
    localparam int BW = 16;
    localparam int PW = 8;
    localparam int TW = 20;

    // one stored process
    typedef struct packed {
        logic [IDW-1:0] id;
        logic [BW-1:0]  burst;
        logic [PW-1:0]  prio;
    } t_entry;

    // sequencer steps
    localparam int SW = 3;
    localparam logic [SW-1:0] S_IDLE  = 3'd0;
    localparam logic [SW-1:0] S_START = 3'd1;
    localparam logic [SW-1:0] S_RDI   = 3'd2;
    localparam logic [SW-1:0] S_LDI   = 3'd3;
    localparam logic [SW-1:0] S_RDJ   = 3'd4;
    localparam logic [SW-1:0] S_CMP   = 3'd5;
    localparam logic [SW-1:0] S_EMIT  = 3'd6;
    localparam logic [SW-1:0] S_ADV   = 3'd7;

    // jump conditions
    localparam logic [2:0] C_NEVER     = 3'd0;
    localparam logic [2:0] C_ALWAYS    = 3'd1;
    localparam logic [2:0] C_LOAD_LAST = 3'd2;
    localparam logic [2:0] C_LAST_I    = 3'd3;
    localparam logic [2:0] C_J_END     = 3'd4;
    localparam logic [2:0] C_OUT_BUSY  = 3'd5;

    // control word: action strobes plus two-way branch
    typedef struct packed {
        logic          load;   // take input requests
        logic          clr;    // i = 0, wait = 0
        logic          rd_i;   // read address i (else j)
        logic          ld_cur; // cur = read data, j = i + 1
        logic          cmp;    // compare read data with cur, maybe exchange, j++
        logic          emit;   // load output register from cur
        logic          adv;    // i++, close the set after the final result
        logic [2:0]    cond;
        logic [SW-1:0] jmp;
        logic [SW-1:0] nxt;
    } t_uword;

    function automatic t_uword ucode(input logic [SW-1:0] pc);
        t_uword w;
        w = '0;
        case (pc)
            S_IDLE: begin
                w.load = 1'b1; w.cond = C_LOAD_LAST; w.jmp = S_START; w.nxt = S_IDLE;
            end
            S_START: begin
                w.clr = 1'b1; w.cond = C_ALWAYS; w.jmp = S_RDI; w.nxt = S_RDI;
            end
            S_RDI: begin
                w.rd_i = 1'b1; w.cond = C_NEVER; w.jmp = S_LDI; w.nxt = S_LDI;
            end
            S_LDI: begin
                w.ld_cur = 1'b1; w.cond = C_LAST_I; w.jmp = S_EMIT; w.nxt = S_RDJ;
            end
            S_RDJ: begin
                w.cond = C_J_END; w.jmp = S_EMIT; w.nxt = S_CMP;
            end
            S_CMP: begin
                w.cmp = 1'b1; w.cond = C_ALWAYS; w.jmp = S_RDJ; w.nxt = S_RDJ;
            end
            S_EMIT: begin
                w.emit = 1'b1; w.cond = C_OUT_BUSY; w.jmp = S_EMIT; w.nxt = S_ADV;
            end
            S_ADV: begin
                w.adv = 1'b1; w.cond = C_LAST_I; w.jmp = S_IDLE; w.nxt = S_RDI;
            end
            default: begin
                w.cond = C_ALWAYS; w.jmp = S_IDLE; w.nxt = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* design/priority_schedule_wait_times_top.sv */
// Non-preemptive priority scheduler, top level: entry memory, microcoded sequencer.
// Depends on psw_pkg and priority_schedule_wait_times_top_defines.svh.

// Processes load at one request per cycle while the block is idle; each is
// numbered 1, 2, 3 ... in arrival order and requests beyond MAX_PROCS are
// dropped. A request with i_last_process set starts scheduling: an exchange
// sort on priority (smaller first; ties fall as the exchange sort leaves them)
// driven by a microcode sequencer over an entry memory with one write port and
// one registered read port. Pass i holds the running minimum in a register
// and visits every later entry in turn; an output stall holds the sequencer
// in its emit step. Results come out in execution order with waiting and
// turnaround times; o_final_result marks the last one. No request is taken
// until the final result of the set has been loaded into the output register.
module priority_schedule_wait_times_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [psw_pkg::BW-1:0]  i_burst_time,
    input  logic [psw_pkg::PW-1:0]  i_priority_level,
    input  logic                    i_last_process,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [psw_pkg::IDW-1:0] o_process_id,
    output logic [psw_pkg::BW-1:0]  o_burst_out,
    output logic [psw_pkg::PW-1:0]  o_priority_out,
    output logic [psw_pkg::TW-1:0]  o_wait_time,
    output logic [psw_pkg::TW-1:0]  o_turnaround_time,
    output logic                    o_final_result
);
    import psw_pkg::*;
`include "priority_schedule_wait_times_top_defines.svh"

    // sequencer and datapath registers
    logic [SW-1:0] r_pc, n_pc;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic [TW-1:0] r_wait;
    t_entry        r_cur;
    t_entry        r_rd;
    t_entry        mem [MAX_PROCS];
    logic          r_ovalid;

    t_uword        uw;
    logic          in_acc;
    logic          out_free;
    logic          i_is_last;
    logic          swap;
    logic          take;
    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    t_entry        wdata;
    logic [TW-1:0] turn;

    // decode
    always_comb begin
        uw        = ucode(r_pc);
        in_acc    = uw.load && i_valid;
        out_free  = !r_ovalid || i_ready;
        i_is_last = ((CW'(r_i) + CW'(1)) == r_count);
        swap      = (r_rd.prio < r_cur.prio);
        turn      = r_wait + TW'(r_cur.burst);
    end

    // branch
    always_comb begin
        case (uw.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_LOAD_LAST: take = in_acc && i_last_process;
            C_LAST_I:    take = i_is_last;
            C_J_END:     take = (r_j == r_count);
            C_OUT_BUSY:  take = !out_free;
            default:     take = 1'b0;
        endcase
        n_pc = take ? uw.jmp : uw.nxt;
    end

    // memory port selection: load writes at the fill count, exchange at j
    always_comb begin
        we       = (in_acc && (r_count < CW'(MAX_PROCS))) || (uw.cmp && swap);
        waddr    = uw.load ? r_count[AW-1:0] : r_j[AW-1:0];
        wdata.id    = uw.load ? IDW'(r_count + CW'(1)) : r_cur.id;
        wdata.burst = uw.load ? i_burst_time : r_cur.burst;
        wdata.prio  = uw.load ? i_priority_level : r_cur.prio;
        raddr    = uw.rd_i ? r_i : r_j[AW-1:0];
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd <= mem[raddr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (in_acc && (r_count < CW'(MAX_PROCS))) begin
                r_count <= r_count + CW'(1);
            end
            if (uw.adv && i_is_last) begin
                r_count <= '0;
            end
            if (uw.emit && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // sort and emit datapath
    always_ff @(posedge i_clk) begin
        if (uw.clr) begin
            r_i    <= '0;
            r_wait <= '0;
        end
        if (uw.ld_cur) begin
            r_cur <= r_rd;
            r_j   <= CW'(r_i) + CW'(1);
        end
        if (uw.cmp) begin
            if (swap) begin
                r_cur <= r_rd;
            end
            r_j <= r_j + CW'(1);
        end
        if (uw.emit && out_free) begin
            o_process_id      <= r_cur.id;
            o_burst_out       <= r_cur.burst;
            o_priority_out    <= r_cur.prio;
            o_wait_time       <= r_wait;
            o_turnaround_time <= turn;
            o_final_result    <= i_is_last;
            r_wait            <= turn;
        end
        if (uw.adv) begin
            r_i <= r_i + AW'(1);
        end
    end

    assign o_ready = uw.load;
    assign o_valid = r_ovalid;

    // checks
    `PSW_ASSERT_NOW(a_busy_has_entries, i_clk, i_rst_n, r_pc != S_IDLE, r_count != '0)
    `PSW_ASSERT_NOW(a_i_in_range, i_clk, i_rst_n,
        (r_pc != S_IDLE) && (r_pc != S_START), CW'(r_i) < r_count)
    `PSW_ASSERT_NOW(a_j_after_i, i_clk, i_rst_n,
        (r_pc == S_RDJ) || (r_pc == S_CMP), (r_j > CW'(r_i)) && (r_j <= r_count))
    `PSW_ASSERT_NEXT(a_set_closes, i_clk, i_rst_n,
        (r_pc == S_ADV) && i_is_last, (r_pc == S_IDLE) && (r_count == '0))

endmodule
